[design/adjacency_list_store_top_defines.svh]
// assertion macros for the adjacency list store
// used by adjacency_list_store_top, no other dependencies
`ifndef ADJACENCY_LIST_STORE_TOP_DEFINES_SVH
`define ADJACENCY_LIST_STORE_TOP_DEFINES_SVH

// same-cycle implication, sampled on clk, off during rst
`define ALST_CHECK_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, sampled on clk, off during rst
`define ALST_CHECK_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

[design/alst_pkg.sv]
// shared types and constants for the adjacency list store
// no dependencies
package alst_pkg;

  localparam int VERTEX_W     = 7;
  localparam int DEGREE_W     = 7;
  localparam int RESULT_LIMIT = 64;

  localparam logic [1:0] FUNC_ADD   = 2'd0;
  localparam logic [1:0] FUNC_QUERY = 2'd1;
  localparam logic [1:0] FUNC_LIST  = 2'd2;
  localparam logic [1:0] FUNC_CLEAR = 2'd3;

  typedef struct packed {
    logic                status;
    logic                found;
    logic [DEGREE_W-1:0] vertex_degree;
    logic [VERTEX_W-1:0] neighbour;
    logic                neighbour_valid;
    logic                last;
  } result_t;

endpackage

[design/alst_ram.sv]
// generic simple dual-port ram, one write and one registered read port
// no dependencies
module alst_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[design/alst_obuf.sv]
// one-entry output register between the sequencer and the result stream
// depends on alst_pkg
module alst_obuf
  import alst_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    push,
  input  result_t push_res,
  output logic    push_ready,
  output logic    out_valid,
  output result_t out_res,
  input  logic    out_ready
);

  assign push_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (push_ready) begin
      out_valid <= push;
    end
  end

  always_ff @(posedge clk) begin
    if (push && push_ready) begin
      out_res <= push_res;
    end
  end

endmodule

[design/adjacency_list_store_top.sv]
// adjacency list store: sequencer around a list-length ram and a neighbour ram
// depends on alst_pkg, alst_ram, alst_obuf and adjacency_list_store_top_defines.svh
// throughput: one request at a time; the scans run one neighbour ram read per cycle,
//   except that a list scan holds while the output register is full
// reset: after rst falls, a clearing pass zeroes the length ram,
//   no request is taken meanwhile; configuration writes are taken at any time
`include "adjacency_list_store_top_defines.svh"

module adjacency_list_store_top
  import alst_pkg::*;
#(
  parameter int VERTICES   = 128,
  parameter int MAX_DEGREE = 64
) (
  input  logic        clk,
  input  logic        rst,
  // configuration: vertex_count
  input  logic        cfg_wen,
  input  logic [6:0]  cfg_wdata,
  // request stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,  // first_vertex[6:0], second_vertex[13:7], zero fill
  input  logic [1:0]  s_axis_tuser,  // func[1:0]
  // result stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,  // status[0], found[1], vertex_degree[8:2], neighbour[15:9]
  output logic        m_axis_tuser,  // neighbour_valid[0]
  output logic        m_axis_tlast
);

  // vertex index, slot index and length widths
  localparam int VW = $clog2(VERTICES);
  localparam int IW = $clog2(MAX_DEGREE);
  localparam int LW = $clog2(MAX_DEGREE + 1);

  // sequencer states
  localparam logic [3:0] S_INIT  = 4'd0;  // clearing pass after reset
  localparam logic [3:0] S_IDLE  = 4'd1;  // waiting for a request
  localparam logic [3:0] S_RDX   = 4'd2;  // length of x arrives
  localparam logic [3:0] S_RDY   = 4'd3;  // length of y arrives, first write
  localparam logic [3:0] S_WRY   = 4'd4;  // second write of an edge
  localparam logic [3:0] S_SCAN  = 4'd5;  // one list entry per cycle, a list held while the output register is full
  localparam logic [3:0] S_CLR   = 4'd6;  // clear sweep
  localparam logic [3:0] S_RDLEN = 4'd7;  // reread x's length after a clear
  localparam logic [3:0] S_EMIT  = 4'd8;  // single result waits for the output register

  logic [3:0]          state;
  logic [3:0]          state_next;
  logic [6:0]          vertex_count;
  logic [1:0]          func_r;
  logic [VERTEX_W-1:0] x_r;
  logic [VERTEX_W-1:0] y_r;
  logic                x_ok;
  logic                y_ok;
  logic [LW-1:0]       lenx_r;
  logic [IW-1:0]       slot_y_r;
  logic [DEGREE_W-1:0] deg_r;
  logic                status_r;
  logic                found_r;
  logic [IW-1:0]       scan_idx;
  logic [LW-1:0]       scan_n;
  logic [VW-1:0]       clr_cnt;

  // ram ports
  logic          len_we;
  logic [VW-1:0] len_waddr;
  logic [LW-1:0] len_wdata;
  logic [VW-1:0] len_raddr;
  logic [LW-1:0] len_rdata;
  logic                nbr_we;
  logic [VW+IW-1:0]    nbr_waddr;
  logic [VERTEX_W-1:0] nbr_wdata;
  logic [VW+IW-1:0]    nbr_raddr;
  logic [VERTEX_W-1:0] nbr_rdata;

  // output register side
  logic    push;
  result_t push_res;
  logic    push_ready;
  result_t out_res;

  logic                in_accept;
  logic [VERTEX_W-1:0] in_x;
  logic [VERTEX_W-1:0] in_y;
  logic [VW-1:0]       x_addr;
  logic [VW-1:0]       y_addr;
  logic [LW-1:0]       lenx;
  logic [LW-1:0]       leny;
  logic [1:0]          need;
  logic                room;
  logic                scan_last;
  logic                scan_hit;
  logic [IW-1:0]       scan_inc;
  logic [VW-1:0]       clr_end;

  assign in_x      = s_axis_tdata[6:0];
  assign in_y      = s_axis_tdata[13:7];
  assign in_accept = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = (state == S_IDLE);

  assign x_addr = VW'(x_r);
  assign y_addr = VW'(y_r);

  // out-of-range vertices read as an empty list
  assign lenx = x_ok ? len_rdata : '0;
  assign leny = y_ok ? len_rdata : '0;

  // a self-loop takes two slots of the same list
  assign need = (x_r == y_r) ? 2'd2 : 2'd1;
  assign room = x_ok && y_ok &&
                (32'(lenx_r) + 32'(need) <= MAX_DEGREE) &&
                (32'(leny) + 32'(need) <= MAX_DEGREE);

  assign scan_inc  = IW'(32'(scan_idx) + 1);
  assign scan_last = (32'(scan_idx) + 1 == 32'(scan_n));
  assign scan_hit  = (nbr_rdata == y_r);

  // sweep ends at vertex_count or at the last vertex, whichever is lower
  assign clr_end = (32'(vertex_count) < VERTICES) ? VW'(vertex_count) : VW'(VERTICES - 1);

  // configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      vertex_count <= 7'd127;
    end else if (cfg_wen) begin
      vertex_count <= cfg_wdata;
    end
  end

  // ram addressing and result pushes
  always_comb begin
    state_next = state;
    len_we     = 1'b0;
    len_waddr  = x_addr;
    len_wdata  = '0;
    len_raddr  = x_addr;
    nbr_we     = 1'b0;
    nbr_waddr  = {x_addr, IW'(lenx_r)};
    nbr_wdata  = y_r;
    nbr_raddr  = {x_addr, scan_inc};
    push       = 1'b0;
    push_res   = '{status: status_r, found: found_r, vertex_degree: deg_r,
                   neighbour: '0, neighbour_valid: 1'b0, last: 1'b1};
    case (state)
      S_INIT: begin
        len_we    = 1'b1;
        len_waddr = clr_cnt;
        if (clr_cnt == VW'(VERTICES - 1)) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        len_raddr = VW'(in_x);
        if (in_accept) begin
          if (s_axis_tuser == FUNC_CLEAR && vertex_count != 7'd0) begin
            state_next = S_CLR;
          end else begin
            state_next = S_RDX;
          end
        end
      end
      S_RDX: begin
        // the y length read goes out here for an edge
        len_raddr = y_addr;
        nbr_raddr = {x_addr, IW'(0)};
        case (func_r)
          FUNC_ADD: state_next = S_RDY;
          FUNC_QUERY, FUNC_LIST: begin
            state_next = (lenx == '0) ? S_EMIT : S_SCAN;
          end
          default: state_next = S_EMIT;
        endcase
      end
      S_RDY: begin
        if (room) begin
          nbr_we     = 1'b1;
          len_we     = 1'b1;
          len_wdata  = LW'(32'(lenx_r) + 1);
          state_next = S_WRY;
        end else begin
          state_next = S_EMIT;
        end
      end
      S_WRY: begin
        nbr_we     = 1'b1;
        nbr_waddr  = {y_addr, slot_y_r};
        nbr_wdata  = x_r;
        len_we     = 1'b1;
        len_waddr  = y_addr;
        len_wdata  = LW'(32'(slot_y_r) + 1);
        state_next = S_EMIT;
      end
      S_SCAN: begin
        if (func_r == FUNC_LIST) begin
          push     = 1'b1;
          push_res = '{status: 1'b0, found: 1'b0, vertex_degree: deg_r,
                       neighbour: nbr_rdata, neighbour_valid: 1'b1, last: scan_last};
          // hold the read address while the output register is full
          nbr_raddr = push_ready ? {x_addr, scan_inc} : {x_addr, scan_idx};
          if (push_ready && scan_last) begin
            state_next = S_IDLE;
          end
        end else if (scan_hit || scan_last) begin
          state_next = S_EMIT;
        end
      end
      S_CLR: begin
        len_we    = 1'b1;
        len_waddr = clr_cnt;
        if (clr_cnt == clr_end) begin
          state_next = S_RDLEN;
        end
      end
      S_RDLEN: state_next = S_RDX;
      S_EMIT: begin
        push = 1'b1;
        if (push_ready) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_INIT;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_INIT;
      clr_cnt <= '0;
    end else begin
      state <= state_next;
      if (state == S_INIT || state == S_CLR) begin
        clr_cnt <= clr_cnt + VW'(1);
      end else if (in_accept) begin
        // a clear sweep starts at vertex 1
        clr_cnt <= VW'(1);
      end
    end
  end

  // request and working registers
  always_ff @(posedge clk) begin
    if (in_accept) begin
      func_r   <= s_axis_tuser;
      x_r      <= in_x;
      y_r      <= in_y;
      x_ok     <= (32'(in_x) < VERTICES);
      y_ok     <= (32'(in_y) < VERTICES);
      status_r <= 1'b0;
      found_r  <= 1'b0;
    end
    case (state)
      S_RDX: begin
        lenx_r   <= lenx;
        deg_r    <= DEGREE_W'(lenx);
        scan_idx <= '0;
        // only a list is cut at the result limit, a query scans until a hit or the end of the list
        scan_n   <= (func_r == FUNC_LIST && 32'(lenx) > RESULT_LIMIT) ?
                    LW'(RESULT_LIMIT) : lenx;
      end
      S_RDY: begin
        if (room) begin
          deg_r    <= DEGREE_W'(32'(lenx_r) + 32'(need));
          slot_y_r <= (x_r == y_r) ? IW'(32'(leny) + 1) : IW'(leny);
        end else begin
          status_r <= 1'b1;
        end
      end
      S_SCAN: begin
        if (func_r == FUNC_LIST) begin
          if (push_ready) begin
            scan_idx <= scan_inc;
          end
        end else begin
          scan_idx <= scan_inc;
          if (scan_hit) begin
            found_r <= 1'b1;
          end
        end
      end
      default: begin
      end
    endcase
  end

  // per-vertex list lengths
  alst_ram #(
    .WIDTH (LW),
    .DEPTH (VERTICES)
  ) u_len_ram (
    .clk   (clk),
    .we    (len_we),
    .waddr (len_waddr),
    .wdata (len_wdata),
    .raddr (len_raddr),
    .rdata (len_rdata)
  );

  // neighbour entries, one row of 2**IW slots per vertex
  alst_ram #(
    .WIDTH (VERTEX_W),
    .DEPTH (VERTICES << IW)
  ) u_nbr_ram (
    .clk   (clk),
    .we    (nbr_we),
    .waddr (nbr_waddr),
    .wdata (nbr_wdata),
    .raddr (nbr_raddr),
    .rdata (nbr_rdata)
  );

  // output register decouples the sequencer from the result stream
  alst_obuf u_obuf (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_res   (push_res),
    .push_ready (push_ready),
    .out_valid  (m_axis_tvalid),
    .out_res    (out_res),
    .out_ready  (m_axis_tready)
  );

  assign m_axis_tdata = {out_res.neighbour, out_res.vertex_degree,
                         out_res.found, out_res.status};
  assign m_axis_tuser = out_res.neighbour_valid;
  assign m_axis_tlast = out_res.last;

  // checks
  `ALST_CHECK_SAME(a_init_quiet, state == S_INIT, !m_axis_tvalid, "result offered during clearing pass")
  `ALST_CHECK_NEXT(a_one_request, in_accept, !s_axis_tready, "second request taken while busy")
  `ALST_CHECK_SAME(a_edge_room, nbr_we && state == S_RDY, 32'(lenx_r) < MAX_DEGREE, "edge written into a full list")
  `ALST_CHECK_SAME(a_scan_bound, state == S_SCAN, 32'(scan_idx) < 32'(scan_n), "scan ran past the list length")

endmodule

[tb/tb_top.sv]
// self-checking bench for adjacency_list_store_top: request and result streams with
// random gaps, a long result hold-off and a cycle-accurate-free graph predictor
// depends on alst_pkg and the adjacency_list_store_top rtl
`timescale 1ns / 100ps

module tb_top;
  import alst_pkg::*;

  localparam int VERTICES   = 128;
  localparam int MAX_DEGREE = 64;
  localparam int CYCLE_CAP  = 400000;
  localparam int HOLD_CYCLES = 300;
  localparam int DRAIN_CYCLES = 150;  // longer than a full clear sweep

  // one graph request as it travels on the request stream
  typedef struct packed {
    logic [1:0]          func;
    logic [VERTEX_W-1:0] x;
    logic [VERTEX_W-1:0] y;
  } graph_req_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_wen = 1'b0;
  logic [6:0]  cfg_wdata = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [15:0] s_axis_tdata = '0;  // first_vertex[6:0], second_vertex[13:7], zero fill
  logic [1:0]  s_axis_tuser = '0;  // func[1:0]
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [15:0] m_axis_tdata;       // status[0], found[1], vertex_degree[8:2], neighbour[15:9]
  logic        m_axis_tuser;       // neighbour_valid[0]
  logic        m_axis_tlast;

  adjacency_list_store_top #(
    .VERTICES  (VERTICES),
    .MAX_DEGREE(MAX_DEGREE)
  ) uut (
    .clk          (clk),
    .rst          (rst),
    .cfg_wen      (cfg_wen),
    .cfg_wdata    (cfg_wdata),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .m_axis_tlast (m_axis_tlast)
  );

  // shadow graph: per-vertex length and neighbour entries, plus the clear bound
  int                  deg_tab [VERTICES];
  logic [VERTEX_W-1:0] nbr_tab [VERTICES][MAX_DEGREE];
  int                  clear_bound;

  graph_req_t graph_ops_q[$];    // requests waiting to be offered
  result_t    graph_answers[$];  // results the block still owes, oldest first

  graph_req_t cur_req;
  logic       req_taken = 1'b0;
  logic       steady = 1'b0;     // no random idling on either side while set
  logic       hold_req = 1'b0;
  int         hold_left = 0;
  int         cycles = 0;

  // run statistics
  int      mismatches = 0;
  int      results_checked = 0;
  int      func_seen [4];
  int      rejects_seen = 0;
  int      hits_seen = 0;
  int      longest_list = 0;
  result_t got, want;

  initial begin
    forever #1 clk = ~clk;
  end

  // append one owed result at the tail of the result queue
  task automatic owe_result(input result_t r);
    graph_answers.insert(graph_answers.size(), r);
  endtask

  // work out what one accepted request must produce and update the shadow graph
  task automatic graph_op(input graph_req_t op);
    int      need;
    int      n;
    int      i;
    int      xi;
    int      yi;
    result_t r;
    xi = int'(op.x);
    yi = int'(op.y);
    r = '0;
    r.last = 1'b1;
    case (op.func)
      FUNC_ADD: begin
        // a self-loop lands twice in the same list, so it needs two free slots
        need = (xi == yi) ? 2 : 1;
        if (deg_tab[xi] + need <= MAX_DEGREE && deg_tab[yi] + need <= MAX_DEGREE) begin
          nbr_tab[xi][deg_tab[xi]] = op.y;
          deg_tab[xi]++;
          nbr_tab[yi][deg_tab[yi]] = op.x;
          deg_tab[yi]++;
        end else begin
          r.status = 1'b1;
        end
        r.vertex_degree = DEGREE_W'(deg_tab[xi]);
        owe_result(r);
      end
      FUNC_QUERY: begin
        for (i = 0; i < deg_tab[xi]; i++) begin
          if (nbr_tab[xi][i] == op.y) r.found = 1'b1;
        end
        r.vertex_degree = DEGREE_W'(deg_tab[xi]);
        owe_result(r);
      end
      FUNC_LIST: begin
        n = (deg_tab[xi] < RESULT_LIMIT) ? deg_tab[xi] : RESULT_LIMIT;
        r.vertex_degree = DEGREE_W'(deg_tab[xi]);
        if (n == 0) begin
          owe_result(r);
        end else begin
          if (n > longest_list) longest_list = n;
          for (i = 0; i < n; i++) begin
            r.neighbour       = nbr_tab[xi][i];
            r.neighbour_valid = 1'b1;
            r.last            = (i == n - 1);
            owe_result(r);
          end
        end
      end
      FUNC_CLEAR: begin
        // vertex 0 always survives a clear
        for (i = 1; i <= clear_bound && i < VERTICES; i++) deg_tab[i] = 0;
        r.vertex_degree = DEGREE_W'(deg_tab[xi]);
        owe_result(r);
      end
      default: ;
    endcase
  endtask

  task automatic queue_op(input logic [1:0] f, input int a, input int b);
    graph_req_t op;
    op.func = f;
    op.x = VERTEX_W'(a);
    op.y = VERTEX_W'(b);
    graph_ops_q.insert(graph_ops_q.size(), op);
  endtask

  // block until every request went out and every owed result came back
  task automatic wait_idle();
    while (graph_ops_q.size() != 0 || s_axis_tvalid || graph_answers.size() != 0)
      @(posedge clk);
  endtask

  // vertex_count may only change with nothing in flight
  task automatic set_clear_bound(input int v);
    wait_idle();
    @(negedge clk);
    cfg_wen   <= 1'b1;
    cfg_wdata <= 7'(v);
    clear_bound = v;
    @(negedge clk);
    cfg_wen <= 1'b0;
  endtask

  // mostly well-formed traffic over a small vertex pool so lists grow long and
  // queries hit, with some full-range noise to reach every vertex bit
  task automatic random_phase(input int count);
    int pool [10];
    int k;
    int pick;
    int a;
    int b;
    for (k = 0; k < 10; k++) pool[k] = $urandom_range(0, VERTICES - 1);
    for (k = 0; k < count; k++) begin
      pick = $urandom_range(0, 99);
      a = pool[$urandom_range(0, 9)];
      b = pool[$urandom_range(0, 9)];
      if (pick < 45) queue_op(FUNC_ADD, a, b);
      else if (pick < 65) queue_op(FUNC_QUERY, a, b);
      else if (pick < 80) queue_op(FUNC_LIST, a, b);
      else if (pick < 83) queue_op(FUNC_CLEAR, a, b);
      else queue_op(2'($urandom_range(0, 3)), $urandom_range(0, VERTICES - 1),
                    $urandom_range(0, VERTICES - 1));
    end
  endtask

  // fill one vertex to the brim, then bounce edges off it and read it back whole
  task automatic hub_phase();
    int hub;
    int k;
    int other;
    hub = $urandom_range(1, VERTICES - 2);
    for (k = 0; k < MAX_DEGREE - 1; k++) begin
      other = (hub + 1 + $urandom_range(0, VERTICES - 2)) % VERTICES;
      queue_op(FUNC_ADD, hub, other);
    end
    queue_op(FUNC_ADD, hub, hub);          // self-loop needs two slots, only one left
    queue_op(FUNC_ADD, hub, other);        // takes the last slot
    queue_op(FUNC_ADD, other, hub);        // rejected, hub list already full
    queue_op(FUNC_LIST, hub, 0);           // longest possible list
    queue_op(FUNC_QUERY, hub, other);
    queue_op(FUNC_QUERY, hub, hub);
    queue_op(FUNC_CLEAR, hub, 0);
    queue_op(FUNC_LIST, hub, 0);
  endtask

  // request driver: holds a request until taken, otherwise offers the next one
  // or idles at random
  always @(negedge clk) begin
    if (rst || (s_axis_tvalid && !req_taken)) begin
      // reset still on, or the current request waits for its handshake
    end else if (graph_ops_q.size() != 0 && (steady || $urandom_range(0, 99) >= 29)) begin
      cur_req = graph_ops_q.pop_front();
      s_axis_tvalid <= 1'b1;
      s_axis_tdata  <= {2'b00, cur_req.y, cur_req.x};
      s_axis_tuser  <= cur_req.func;
    end else begin
      s_axis_tvalid <= 1'b0;
    end
    req_taken = 1'b0;
  end

  // result receiver: random stalls, plus one long hold-off when asked
  always @(negedge clk) begin
    if (hold_left > 0) begin
      hold_left = hold_left - 1;
      m_axis_tready <= 1'b0;
    end else if (hold_req) begin
      hold_req  = 1'b0;
      hold_left = HOLD_CYCLES;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= steady || ($urandom_range(0, 99) >= 29);
    end
  end

  // monitor first, then predictor, so a result and a new request in one cycle
  // never race on the result queue
  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got.status          = m_axis_tdata[0];
      got.found           = m_axis_tdata[1];
      got.vertex_degree   = m_axis_tdata[8:2];
      got.neighbour       = m_axis_tdata[15:9];
      got.neighbour_valid = m_axis_tuser;
      got.last            = m_axis_tlast;
      if (graph_answers.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("[%0t] result with nothing owed: status %0d found %0d deg %0d nbr %0d vld %0d last %0d",
                   $realtime, got.status, got.found, got.vertex_degree, got.neighbour,
                   got.neighbour_valid, got.last);
      end else begin
        want = graph_answers.pop_front();
        results_checked++;
        if (got.status !== want.status || got.found !== want.found ||
            got.vertex_degree !== want.vertex_degree || got.neighbour !== want.neighbour ||
            got.neighbour_valid !== want.neighbour_valid || got.last !== want.last) begin
          mismatches++;
          if (mismatches <= 10)
            $display("[%0t] result mismatch: want status %0d found %0d deg %0d nbr %0d vld %0d last %0d, got status %0d found %0d deg %0d nbr %0d vld %0d last %0d",
                     $realtime, want.status, want.found, want.vertex_degree, want.neighbour,
                     want.neighbour_valid, want.last, got.status, got.found,
                     got.vertex_degree, got.neighbour, got.neighbour_valid, got.last);
        end
        if (want.status) rejects_seen++;
        if (want.found) hits_seen++;
      end
    end
    if (!rst && s_axis_tvalid && s_axis_tready) begin
      func_seen[cur_req.func]++;
      graph_op(cur_req);
      req_taken = 1'b1;
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_CAP) begin
      $display("FAIL adjacency_list_store_top");
      $finish;
    end
  end

  initial begin
    for (int i = 0; i < VERTICES; i++) deg_tab[i] = 0;
    for (int i = 0; i < 4; i++) func_seen[i] = 0;
    clear_bound = 127;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed: empty lists, extreme vertices, self-loops, hits and misses
    set_clear_bound(127);
    queue_op(FUNC_LIST, 5, 0);
    queue_op(FUNC_QUERY, 5, 7);
    queue_op(FUNC_ADD, 0, 127);
    queue_op(FUNC_ADD, 127, 127);
    queue_op(FUNC_ADD, 5, 7);
    queue_op(FUNC_ADD, 5, 9);
    queue_op(FUNC_ADD, 5, 5);
    queue_op(FUNC_QUERY, 5, 7);
    queue_op(FUNC_QUERY, 5, 8);
    queue_op(FUNC_QUERY, 127, 127);
    queue_op(FUNC_QUERY, 0, 127);
    queue_op(FUNC_LIST, 5, 0);
    queue_op(FUNC_LIST, 127, 0);
    queue_op(FUNC_LIST, 0, 0);
    queue_op(FUNC_CLEAR, 5, 0);
    queue_op(FUNC_LIST, 5, 0);
    queue_op(FUNC_LIST, 0, 0);        // vertex 0 keeps its entry
    queue_op(FUNC_QUERY, 127, 0);

    // clear bound of one: only vertex 1 is emptied
    set_clear_bound(1);
    queue_op(FUNC_ADD, 1, 2);
    queue_op(FUNC_ADD, 2, 3);
    queue_op(FUNC_CLEAR, 2, 0);
    queue_op(FUNC_LIST, 2, 0);
    queue_op(FUNC_LIST, 1, 0);

    // clear bound of zero: clear touches nothing
    set_clear_bound(0);
    queue_op(FUNC_CLEAR, 2, 0);
    queue_op(FUNC_QUERY, 2, 3);

    // full list with no idling, and the receiver holding off meanwhile
    set_clear_bound(127);
    @(posedge clk);
    steady   = 1'b1;
    hold_req = 1'b1;
    hub_phase();
    wait_idle();
    steady = 1'b0;

    // random traffic under a few clear bounds
    set_clear_bound($urandom_range(2, 126));
    random_phase(65);
    set_clear_bound(127);
    random_phase(65);
    set_clear_bound(1);
    random_phase(65);

    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("covered %0d adds (%0d rejected), %0d queries (%0d hits), %0d lists (longest %0d), %0d clears",
             func_seen[FUNC_ADD], rejects_seen, func_seen[FUNC_QUERY], hits_seen,
             func_seen[FUNC_LIST], longest_list, func_seen[FUNC_CLEAR]);
    $display("%0d results checked, %0d mismatches, %0d cycles", results_checked, mismatches,
             cycles);
    if (mismatches == 0 && graph_answers.size() == 0) begin
      $display("PASS adjacency_list_store_top");
    end else begin
      $display("FAIL adjacency_list_store_top");
    end
    $finish;
  end

endmodule

[adjacency_list_store_top.f]
+incdir+design
design/alst_pkg.sv
design/alst_ram.sv
design/alst_obuf.sv
design/adjacency_list_store_top.sv
tb/tb_top.sv
